// File: hdl/plsr_pkg.sv
// Shared types, constants and the divider step for the PLL register word block.
`default_nettype none
package plsr_pkg;

  localparam int VCO_W          = 22;
  localparam int CFG_W          = 16;
  localparam int RWORD_W        = 21;
  localparam int R_W            = 14;
  localparam int B_W            = 13;
  localparam int A_W            = 5;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = (VCO_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  localparam logic [RWORD_W-1:0] INIT_LATCH = RWORD_W'((1 << 7) | (1 << 4) | 3);
  localparam logic [RWORD_W-1:0] FUNC_LATCH = RWORD_W'((1 << 7) | (1 << 4) | 2);
  localparam logic [R_W-1:0]     R_MAX      = '1;
  localparam logic [B_W-1:0]     B_MAX      = '1;
  localparam logic [A_W-1:0]     A_MAX      = '1;
  localparam logic [CFG_W-1:0]   OSC_RESET  = CFG_W'(12800);
  localparam logic [CFG_W-1:0]   PFD_RESET  = CFG_W'(100);

  typedef enum logic [1:0] {
    WORD_INIT = 2'd0,
    WORD_REF  = 2'd1,
    WORD_NCTR = 2'd2,
    WORD_FUNC = 2'd3
  } word_index_t;

  typedef struct packed {
    logic [VCO_W-1:0] work;
    logic [CFG_W-1:0] rem;
  } div_lane_t;

  typedef struct packed {
    div_lane_t n;
    div_lane_t r;
  } div_data_t;

  function automatic div_lane_t div_step(div_lane_t l, logic [CFG_W-1:0] d);
    logic [CFG_W:0] t;
    div_lane_t      o;
    t = {l.rem, l.work[VCO_W-1]};
    if (t >= {1'b0, d}) begin
      o.rem  = CFG_W'(t - {1'b0, d});
      o.work = {l.work[VCO_W-2:0], 1'b1};
    end else begin
      o.rem  = t[CFG_W-1:0];
      o.work = {l.work[VCO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: hdl/plsr_cfg.sv
// APB register file holding the oscillator and comparison frequencies.
`default_nettype none
module plsr_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [plsr_pkg::CFG_W-1:0] osc_khz,
  output logic      [plsr_pkg::CFG_W-1:0] pfd_khz
);
  import plsr_pkg::*;

  localparam logic REG_OSC = 1'b0;
  localparam logic REG_PFD = 1'b1;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      osc_khz <= OSC_RESET;
      pfd_khz <= PFD_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_OSC: osc_khz <= pwdata[CFG_W-1:0];
        REG_PFD: pfd_khz <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OSC: prdata = {{(32-CFG_W){1'b0}}, osc_khz};
      REG_PFD: prdata = {{(32-CFG_W){1'b0}}, pfd_khz};
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/plsr_div_stage.sv
// One divider pipeline stage: two quotient bits for the N and R lanes.
`default_nettype none
module plsr_div_stage (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic [plsr_pkg::CFG_W-1:0] pfd_khz,
  input  wire logic                       valid_in,
  input  wire plsr_pkg::div_data_t        data_in,
  output logic                            valid_out,
  output plsr_pkg::div_data_t             data_out
);
  import plsr_pkg::*;

  div_data_t data_next;

  always_comb begin
    data_next = data_in;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      data_next.n = div_step(data_next.n, pfd_khz);
      data_next.r = div_step(data_next.r, pfd_khz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_out <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/plsr_ser.sv
// Saturation and output register sending four programming words per item.
`default_nettype none
module plsr_ser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         ld_valid,
  input  wire plsr_pkg::div_data_t          ld_data,
  input  wire logic                         pfd_zero,
  output logic                              ld_ready,
  output logic                              word_valid,
  input  wire logic                         word_stall,
  output logic      [plsr_pkg::RWORD_W-1:0] reg_word,
  output logic      [1:0]                   word_index,
  output logic                              out_of_range,
  output logic                              last_word
);
  import plsr_pkg::*;

  word_index_t      idx;
  logic [R_W-1:0]   r_cnt;
  logic [B_W-1:0]   b_cnt;
  logic [A_W-1:0]   a_cnt;
  logic             flag;
  logic             r_ovf;
  logic             b_ovf;
  logic [R_W-1:0]   r_next;
  logic [B_W-1:0]   b_next;
  logic [A_W-1:0]   a_next;
  logic             load;

  assign ld_ready = !word_valid || (!word_stall && idx == WORD_FUNC);
  assign load     = ld_valid && ld_ready;

  assign r_ovf = pfd_zero || (ld_data.r.work[CFG_W-1:R_W] != '0);
  assign b_ovf = pfd_zero || (ld_data.n.work[VCO_W-1:A_W+B_W] != '0);

  always_comb begin
    r_next = r_ovf ? R_MAX : ld_data.r.work[R_W-1:0];
    b_next = b_ovf ? B_MAX : ld_data.n.work[A_W+B_W-1:A_W];
    a_next = b_ovf ? A_MAX : ld_data.n.work[A_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      idx        <= WORD_INIT;
    end else if (load) begin
      word_valid <= 1'b1;
      idx        <= WORD_INIT;
    end else if (word_valid && !word_stall) begin
      idx <= word_index_t'(idx + 2'd1);
      if (idx == WORD_FUNC) begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r_cnt <= r_next;
      b_cnt <= b_next;
      a_cnt <= a_next;
      flag  <= r_ovf || b_ovf;
    end
  end

  always_comb begin
    unique case (idx)
      WORD_INIT: reg_word = INIT_LATCH;
      WORD_REF:  reg_word = {{(RWORD_W-R_W-2){1'b0}}, r_cnt, 2'b00};
      WORD_NCTR: reg_word = {1'b1, b_cnt, a_cnt, 2'b01};
      WORD_FUNC: reg_word = FUNC_LATCH;
      default:   reg_word = INIT_LATCH;
    endcase
  end

  assign word_index   = idx;
  assign out_of_range = flag;
  assign last_word    = (idx == WORD_FUNC);

endmodule
`default_nettype wire

// File: hdl/pll_synth_register_words.sv
// The first word appears after the divider pipeline and output register, then one word a cycle
// while word_stall is low. A frequency transfer can be taken every cycle while vco_stall is low
// into the 11-stage pipeline; the output register loads the next item as the last word leaves.
// Both divisions run in the pipeline at two quotient bits per stage.
// Reset empties the pipeline and output register and loads osc_khz 12800 and pfd_khz 100.
`default_nettype none
module pll_synth_register_words (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  input  wire logic                         vco_valid,
  output logic                              vco_stall,
  input  wire logic [plsr_pkg::VCO_W-1:0]   vco_khz,
  output logic                              word_valid,
  input  wire logic                         word_stall,
  output logic      [plsr_pkg::RWORD_W-1:0] reg_word,
  output logic      [1:0]                   word_index,
  output logic                              out_of_range,
  output logic                              last_word
);
  import plsr_pkg::*;

  logic [CFG_W-1:0] osc_khz;
  logic [CFG_W-1:0] pfd_khz;
  logic             adv;
  logic             ld_ready;
  logic             stage_valid [DIV_STAGES+1];
  div_data_t        stage_data  [DIV_STAGES+1];

  plsr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .osc_khz (osc_khz),
    .pfd_khz (pfd_khz)
  );

  assign adv       = !stage_valid[DIV_STAGES] || ld_ready;
  assign vco_stall = !adv;

  assign stage_valid[0]       = vco_valid && adv;
  assign stage_data[0].n.work = vco_khz;
  assign stage_data[0].n.rem  = '0;
  assign stage_data[0].r.work = {{(VCO_W-CFG_W){1'b0}}, osc_khz};
  assign stage_data[0].r.rem  = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    plsr_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .pfd_khz   (pfd_khz),
      .valid_in  (stage_valid[s]),
      .data_in   (stage_data[s]),
      .valid_out (stage_valid[s+1]),
      .data_out  (stage_data[s+1])
    );
  end

  plsr_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .ld_valid     (stage_valid[DIV_STAGES]),
    .ld_data      (stage_data[DIV_STAGES]),
    .pfd_zero     (pfd_khz == '0),
    .ld_ready     (ld_ready),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .reg_word     (reg_word),
    .word_index   (word_index),
    .out_of_range (out_of_range),
    .last_word    (last_word)
  );

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    vco_valid && !vco_stall |=> stage_valid[1])
    else $error("accepted frequency did not enter the pipeline");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    stage_valid[DIV_STAGES] && !ld_ready |=> stage_valid[DIV_STAGES])
    else $error("pipeline tail lost while stalled");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_stall && !last_word |=> word_valid)
    else $error("word run cut short");

  a_nctr_format: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_index == WORD_NCTR |-> reg_word[RWORD_W-1] && reg_word[0])
    else $error("N counter word control bits wrong");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_stall && word_index == WORD_INIT |=> word_index == WORD_REF)
    else $error("word order broken");
`endif

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Testbench for pll_synth_register_words: PLL programming words checked against a predictor.
`default_nettype none
module tb_top;
  import plsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_PAUSE = 24;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [2:0]  ADDR_OSC    = 3'd0;
  localparam logic [2:0]  ADDR_PFD    = 3'd4;

  typedef struct packed {
    logic [RWORD_W-1:0] word;
    word_index_t        idx;
    logic               sat;
    logic               last;
  } prog_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               vco_valid = 1'b0;
  logic               vco_stall;
  logic [VCO_W-1:0]   vco_khz = '0;
  logic               word_valid;
  logic               word_stall = 1'b0;
  logic [RWORD_W-1:0] reg_word;
  logic [1:0]         word_index;
  logic               out_of_range;
  logic               last_word;

  logic [CFG_W-1:0]   cfg_osc = OSC_RESET;
  logic [CFG_W-1:0]   cfg_pfd = PFD_RESET;
  logic [VCO_W-1:0]   freq_q[$];
  prog_word_t         word_q[$];
  logic               calm = 1'b0;
  logic               hold_arm = 1'b0;
  logic               hold_done = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        cyc = 0;
  int unsigned        err_cnt = 0;
  int unsigned        freq_sent = 0;
  int unsigned        words_seen = 0;
  int unsigned        cfg_writes = 0;
  int unsigned        sat_seen = 0;

  pll_synth_register_words u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .vco_valid(vco_valid), .vco_stall(vco_stall), .vco_khz(vco_khz),
    .word_valid(word_valid), .word_stall(word_stall), .reg_word(reg_word),
    .word_index(word_index), .out_of_range(out_of_range), .last_word(last_word)
  );

  always #5 clk = ~clk;

  function automatic void predict_words(logic [VCO_W-1:0] vco);
    logic [R_W-1:0] r;
    logic [B_W-1:0] b;
    logic [A_W-1:0] a;
    logic           sat;
    int unsigned    rq;
    int unsigned    nq;
    int unsigned    bq;
    prog_word_t     w;
    sat = 1'b0;
    if (cfg_pfd == '0) begin
      r = R_MAX;
      b = B_MAX;
      a = A_MAX;
      sat = 1'b1;
    end else begin
      rq = cfg_osc / cfg_pfd;
      nq = vco / cfg_pfd;
      bq = nq / 32;
      if (rq > R_MAX) begin
        r = R_MAX;
        sat = 1'b1;
      end else begin
        r = R_W'(rq);
      end
      if (bq > B_MAX) begin
        b = B_MAX;
        a = A_MAX;
        sat = 1'b1;
      end else begin
        b = B_W'(bq);
        a = A_W'(nq % 32);
      end
    end
    for (int k = 0; k < 4; k++) begin
      w.idx = word_index_t'(k);
      case (w.idx)
        WORD_INIT: w.word = INIT_LATCH;
        WORD_REF:  w.word = RWORD_W'({r, 2'b00});
        WORD_NCTR: w.word = {1'b1, b, a, 2'b01};
        default:   w.word = FUNC_LATCH;
      endcase
      w.sat  = sat;
      w.last = (k == 3);
      word_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      vco_valid <= 1'b0;
    end else begin
      if (vco_valid && !vco_stall) begin
        predict_words(vco_khz);
        freq_sent++;
      end
      if (!vco_valid || !vco_stall) begin
        if (freq_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          vco_khz   <= freq_q.pop_front();
          vco_valid <= 1'b1;
        end else begin
          vco_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      word_stall <= 1'b0;
    end else begin
      if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        word_stall <= 1'b1;
      end else begin
        word_stall <= !calm && ($urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    prog_word_t e;
    if (!rst && word_valid && !word_stall) begin
      words_seen++;
      if (word_q.size() == 0) begin
        $error("word transfer with nothing expected: reg_word %h", reg_word);
        err_cnt++;
      end else begin
        e = word_q.pop_front();
        if (e.sat) sat_seen++;
        if (reg_word !== e.word) begin
          $error("reg_word: expected %h, got %h", e.word, reg_word);
          err_cnt++;
        end
        if (word_index !== 2'(e.idx)) begin
          $error("word_index: expected %0d, got %0d", e.idx, word_index);
          err_cnt++;
        end
        if (out_of_range !== e.sat) begin
          $error("out_of_range: expected %b, got %b", e.sat, out_of_range);
          err_cnt++;
        end
        if (last_word !== e.last) begin
          $error("last_word: expected %b, got %b", e.last, last_word);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_OSC) cfg_osc = value;
    else cfg_pfd = value;
    cfg_writes++;
  endtask

  task automatic set_dividers(logic [CFG_W-1:0] osc, logic [CFG_W-1:0] pfd);
    reg_write(ADDR_OSC, osc);
    reg_write(ADDR_PFD, pfd);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (freq_q.size() != 0 || vco_valid || word_q.size() != 0);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  function automatic logic [VCO_W-1:0] pick_freq();
    int unsigned edge_n;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return VCO_W'($urandom_range(0, 4194303));
    if (sel < 75) return VCO_W'($urandom_range(0, 65535));
    edge_n = (B_MAX + 1) * 32 * cfg_pfd;
    if (cfg_pfd == '0 || edge_n > 4194303 + 64) return VCO_W'($urandom_range(0, 4194303));
    return VCO_W'(edge_n - 64 + $urandom_range(0, 127));
  endfunction

  task automatic random_burst(int unsigned count);
    repeat (count) freq_q.push_back(pick_freq());
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    freq_q = '{22'd0, 22'd4194303, 22'd1440000, 22'd99, 22'd100};
    wait_drained();

    set_dividers(16'd16383, 16'd1);
    freq_q = '{22'd262143, 22'd262144, 22'd0};
    wait_drained();

    set_dividers(16'd65535, 16'd1);
    freq_q = '{22'd5, 22'd4194303};
    wait_drained();

    set_dividers(16'd12800, 16'd0);
    freq_q = '{22'd0, 22'd4194303, 22'd777};
    wait_drained();

    set_dividers(16'd5, 16'd65535);
    freq_q = '{22'd4194303, 22'd65534, 22'd65535};
    wait_drained();

    set_dividers(16'($urandom()), 16'($urandom_range(1, 40)));
    random_burst(26);

    calm = 1'b1;
    set_dividers(16'($urandom()), 16'($urandom_range(1, 2000)));
    random_burst(26);
    calm = 1'b0;

    hold_arm = 1'b1;
    set_dividers(16'($urandom()), 16'($urandom_range(1, 65535)));
    random_burst(26);
    hold_arm = 1'b0;

    set_dividers(16'd0, 16'($urandom_range(1000, 65535)));
    random_burst(26);

    set_dividers(OSC_RESET, PFD_RESET);
    random_burst(26);

    $display("tb: %0d frequencies, %0d words checked (%0d saturated), %0d register writes",
             freq_sent, words_seen, sat_seen, cfg_writes);
    $display("tb: covered zero and full-scale inputs, R and B clamping, zero comparison rate");
    if (err_cnt == 0 && word_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
